// ===== sv/iiee_pkg.sv =====
`default_nettype none

package iiee_pkg;

	// ASCII codes of the characters the parser knows
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_TIMES  = 8'h2A;
	localparam logic [7:0] CH_DIVIDE = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// Pending operator
	typedef enum logic [2:0] {
		OP_PLUS    = 3'd0,
		OP_MINUS   = 3'd1,
		OP_TIMES   = 3'd2,
		OP_DIVIDE  = 3'd3,
		OP_UNKNOWN = 3'd4
	} op_t;

	// Top-level sequencer
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_START,
		SEQ_WAIT,
		SEQ_FINAL
	} seq_state_t;

	// Multiply/divide unit sequencer
	typedef enum logic [1:0] {
		MDU_IDLE,
		MDU_RUN,
		MDU_FIX
	} mdu_state_t;

	// Input transaction
	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} char_item_t;

	// Output transaction
	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} result_item_t;

	// Request to the multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_req_t;

	function automatic op_t op_code(input logic [7:0] c);
		op_t op;
		unique case (c)
			CH_PLUS:   op = OP_PLUS;
			CH_MINUS:  op = OP_MINUS;
			CH_TIMES:  op = OP_TIMES;
			CH_DIVIDE: op = OP_DIVIDE;
			default:   op = OP_UNKNOWN;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// ===== sv/infix_integer_expression_evaluator_unit.sv =====
`default_nettype none

// Channel   Handshake                    Payload          Transaction
// char      char_valid / char_stall      char_data        one character
// result    result_valid / result_stall  result_data      value and status
//
// Digits, spaces and an operator closing a number under a pending + or - are
// taken while the sequencer stays idle. Closing a number under a pending *
// (or / with a nonzero divisor) runs the bit-serial multiply/divide unit (one
// adder step per bit) through the start and wait states. The last character
// passes through the final state to load the result register. char_stall is
// high whenever the sequencer is not idle; an occupied, stalled output holds
// the final state. Reset clears all expression state; pending op resets to plus.
module infix_integer_expression_evaluator_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  iiee_pkg::char_item_t   char_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output iiee_pkg::result_item_t result_data
);
	import iiee_pkg::*;

	localparam int W = VALUE_WIDTH;

	seq_state_t   state_q, state_d;
	logic [W-1:0] closed_sum_q;
	logic [W-1:0] open_term_q;
	logic [W-1:0] number_acc_q;
	op_t          pending_op_q;
	logic [1:0]   error_q;
	logic         last_q;
	logic         div_q;
	logic         res_valid_q;
	result_item_t res_q;

	logic         take;
	logic         is_digit;
	logic [7:0]   cdiff;
	logic [W-1:0] acc_next;
	logic [W-1:0] neg_num;
	logic         num_zero;
	logic         apply;
	logic         go_mdu;
	op_t          new_op;
	logic [W-1:0] sum_co;
	logic         res_load;
	result_item_t res_d;

	mdu_req_t     mdu_req;
	logic         mdu_done;
	logic [W-1:0] mdu_result;

	// Character decode and number build
	always_comb begin
		cdiff    = char_data.character - CH_ZERO;
		is_digit = (char_data.character >= CH_ZERO) && (char_data.character <= CH_NINE);
		acc_next = number_acc_q;
		if (is_digit) begin
			acc_next = {number_acc_q[W-4:0], 3'b000} + {number_acc_q[W-2:0], 1'b0}
				+ W'(cdiff[3:0]);
		end
		neg_num  = ~acc_next + W'(1);
		num_zero = (acc_next == '0);
		apply    = (!is_digit && char_data.character != CH_SPACE) || char_data.last_char;
		new_op   = op_code(char_data.character);
		go_mdu   = apply && ((pending_op_q == OP_TIMES)
			|| (pending_op_q == OP_DIVIDE && !num_zero));
	end

	assign take   = char_valid && !char_stall;
	assign sum_co = closed_sum_q + open_term_q;

	// Final result word
	always_comb begin
		res_d.status = error_q;
		res_d.value  = (error_q == ST_OK) ? 32'(signed'(sum_co)) : '0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (take) begin
					if (go_mdu) state_d = SEQ_START;
					else if (char_data.last_char) state_d = SEQ_FINAL;
				end
			end
			SEQ_START: state_d = SEQ_WAIT;
			SEQ_WAIT:  if (mdu_done) state_d = last_q ? SEQ_FINAL : SEQ_IDLE;
			SEQ_FINAL: if (res_load) state_d = SEQ_IDLE;
			default:   state_d = SEQ_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		char_stall     = (state_q != SEQ_IDLE);
		mdu_req.start  = (state_q == SEQ_START);
		mdu_req.is_div = div_q;
		res_load       = (state_q == SEQ_FINAL) && (!res_valid_q || !result_stall);
	end

	// Expression state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			closed_sum_q <= '0;
			open_term_q  <= '0;
			number_acc_q <= '0;
			pending_op_q <= OP_PLUS;
			error_q      <= ST_OK;
			last_q       <= 1'b0;
			div_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				SEQ_IDLE: begin
					if (take) begin
						last_q <= char_data.last_char;
						if (apply) begin
							pending_op_q <= new_op;
							unique case (pending_op_q)
								OP_PLUS: begin
									closed_sum_q <= sum_co;
									open_term_q  <= acc_next;
									number_acc_q <= '0;
								end
								OP_MINUS: begin
									closed_sum_q <= sum_co;
									open_term_q  <= neg_num;
									number_acc_q <= '0;
								end
								OP_TIMES: begin
									number_acc_q <= acc_next;
									div_q        <= 1'b0;
								end
								OP_DIVIDE: begin
									if (num_zero) begin
										if (error_q == ST_OK) error_q <= ST_DIVZERO;
										number_acc_q <= '0;
									end else begin
										number_acc_q <= acc_next;
										div_q        <= 1'b1;
									end
								end
								default: begin
									if (error_q == ST_OK) error_q <= ST_UNKNOWN;
									number_acc_q <= '0;
								end
							endcase
						end else begin
							number_acc_q <= acc_next;
						end
					end
				end
				SEQ_START: number_acc_q <= '0;
				SEQ_WAIT:  if (mdu_done) open_term_q <= mdu_result;
				SEQ_FINAL: begin
					if (res_load) begin
						closed_sum_q <= '0;
						open_term_q  <= '0;
						number_acc_q <= '0;
						pending_op_q <= OP_PLUS;
						error_q      <= ST_OK;
						last_q       <= 1'b0;
					end
				end
				default: ;
			endcase

			// Output register occupancy
			if (res_load) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	iiee_mdu #(
		.Width(W)
	) u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mdu_req),
		.op_a  (open_term_q),
		.op_b  (number_acc_q),
		.done  (mdu_done),
		.result(mdu_result)
	);

	// A unit result only arrives while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> state_q == SEQ_WAIT)
		else $error("multiply/divide result outside wait state");

	// The last character blocks further input until its result is loaded
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		take && char_data.last_char |=> char_stall)
		else $error("input accepted after last character");

	// An error status carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.status != ST_OK |-> result_data.value == '0)
		else $error("nonzero value with error status");

endmodule

`default_nettype wire

// ===== sv/iiee_mdu.sv =====
`default_nettype none

// Iterative signed multiply / truncating divide, one bit per cycle on one
// shared adder. Results wrap at Width bits.
module iiee_mdu #(
	parameter int Width = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iiee_pkg::mdu_req_t     req,
	input  logic [Width-1:0]       op_a,
	input  logic [Width-1:0]       op_b,
	output logic                   done,
	output logic [Width-1:0]       result
);
	import iiee_pkg::*;

	localparam int CntW = $clog2(Width);

	mdu_state_t       state_q, state_d;
	logic [CntW-1:0]  cnt_q;
	logic             done_q;
	logic             div_q;
	logic             neg_q;
	logic [Width-1:0] acc_q;
	logic [Width-1:0] opa_q;
	logic [Width-1:0] opb_q;

	logic [Width-1:0] add_x, add_y;
	logic             add_cin;
	logic [Width:0]   add_sum;
	logic [Width-1:0] rem_sh;
	logic [Width-1:0] mag_a, mag_b;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MDU_IDLE: if (req.start) state_d = MDU_RUN;
			MDU_RUN:  if (cnt_q == '0) state_d = MDU_FIX;
			MDU_FIX:  state_d = MDU_IDLE;
			default:  state_d = MDU_IDLE;
		endcase
	end

	// Shared adder and its operand selection
	always_comb begin
		rem_sh  = {acc_q[Width-2:0], opa_q[Width-1]};
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			MDU_RUN: begin
				if (div_q) begin
					// trial subtract of the divisor from the shifted remainder
					add_x   = rem_sh;
					add_y   = ~opb_q;
					add_cin = 1'b1;
				end else begin
					add_x = acc_q;
					add_y = opb_q[0] ? opa_q : '0;
				end
			end
			MDU_FIX: begin
				// quotient sign fix; product passes through
				if (div_q) begin
					add_x   = neg_q ? ~opa_q : opa_q;
					add_cin = neg_q;
				end else begin
					add_x = acc_q;
				end
			end
			default: ;
		endcase
		add_sum = {1'b0, add_x} + {1'b0, add_y} + {{Width{1'b0}}, add_cin};
	end

	// Operand magnitudes for divide
	assign mag_a = op_a[Width-1] ? (~op_a + Width'(1)) : op_a;
	assign mag_b = op_b[Width-1] ? (~op_b + Width'(1)) : op_b;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MDU_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == MDU_FIX);
			if (state_q == MDU_IDLE && req.start) begin
				cnt_q <= CntW'(Width - 1);
			end else if (state_q == MDU_RUN) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			MDU_IDLE: begin
				if (req.start) begin
					div_q <= req.is_div;
					acc_q <= '0;
					if (req.is_div) begin
						opa_q <= mag_a;
						opb_q <= mag_b;
						neg_q <= op_a[Width-1] ^ op_b[Width-1];
					end else begin
						opa_q <= op_a;
						opb_q <= op_b;
						neg_q <= 1'b0;
					end
				end
			end
			MDU_RUN: begin
				if (div_q) begin
					// restoring step: carry out means no borrow
					acc_q <= add_sum[Width] ? add_sum[Width-1:0] : rem_sh;
					opa_q <= {opa_q[Width-2:0], add_sum[Width]};
				end else begin
					acc_q <= add_sum[Width-1:0];
					opa_q <= {opa_q[Width-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[Width-1:1]};
				end
			end
			MDU_FIX: acc_q <= add_sum[Width-1:0];
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

`default_nettype wire

// ===== dv/tb_infix_integer_expression_evaluator_unit.sv =====
`default_nettype none

module tb_infix_integer_expression_evaluator_unit;
	import iiee_pkg::*;

	localparam int MAX_WAIT       = 10;
	localparam int ITEM_GOAL      = 1150;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef logic [7:0] char_q_t[$];

	logic         clk;
	logic         arst_n;
	logic         char_valid;
	logic         char_stall;
	char_item_t   char_data;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_data;

	// Evaluator state as the testbench tracks it
	logic [31:0]  ev_sum    = '0;
	logic [31:0]  ev_term   = '0;
	logic [31:0]  ev_number = '0;
	op_t          ev_op     = OP_PLUS;
	logic [1:0]   ev_error  = ST_OK;

	result_item_t predicted_results[$];
	int           fail_count = 0;
	int           items_sent = 0;
	int           idle_cycles = 0;
	bit           idle_on = 1'b1;

	infix_integer_expression_evaluator_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Apply one accepted character to the tracked state; queue a result on last
	task automatic eval_char(input char_item_t it);
		logic [31:0]  mag_a;
		logic [31:0]  mag_b;
		logic [31:0]  quot;
		logic         is_digit;
		op_t          next_op;
		result_item_t res;
		is_digit = (it.character >= CH_ZERO) && (it.character <= CH_NINE);
		if (is_digit) begin
			ev_number = ev_number * 32'd10 + 32'(it.character - CH_ZERO);
		end
		if ((!is_digit && it.character != CH_SPACE) || it.last_char) begin
			// close the number under the operator seen before it
			case (ev_op)
				OP_PLUS: begin
					ev_sum  = ev_sum + ev_term;
					ev_term = ev_number;
				end
				OP_MINUS: begin
					ev_sum  = ev_sum + ev_term;
					ev_term = -ev_number;
				end
				OP_TIMES: begin
					ev_term = ev_term * ev_number;
				end
				OP_DIVIDE: begin
					if (ev_number == '0) begin
						if (ev_error == ST_OK) ev_error = ST_DIVZERO;
					end else begin
						// truncate toward zero; most negative / -1 wraps to itself
						mag_a   = ev_term[31] ? -ev_term : ev_term;
						mag_b   = ev_number[31] ? -ev_number : ev_number;
						quot    = mag_a / mag_b;
						ev_term = (ev_term[31] ^ ev_number[31]) ? -quot : quot;
					end
				end
				default: begin
					if (ev_error == ST_OK) ev_error = ST_UNKNOWN;
				end
			endcase
			case (it.character)
				CH_PLUS:   next_op = OP_PLUS;
				CH_MINUS:  next_op = OP_MINUS;
				CH_TIMES:  next_op = OP_TIMES;
				CH_DIVIDE: next_op = OP_DIVIDE;
				default:   next_op = OP_UNKNOWN;
			endcase
			ev_op     = next_op;
			ev_number = '0;
		end
		if (it.last_char) begin
			res.status = ev_error;
			res.value  = (ev_error == ST_OK) ? ev_sum + ev_term : '0;
			predicted_results = {predicted_results, res};
			ev_sum    = '0;
			ev_term   = '0;
			ev_number = '0;
			ev_op     = OP_PLUS;
			ev_error  = ST_OK;
		end
	endtask

	// One character transaction; valid stays high afterwards for back-to-back use
	task automatic send_char(input logic [7:0] ch, input logic last);
		char_item_t it;
		int         gap;
		it.character = ch;
		it.last_char = last;
		gap = draw_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= it;
		do @(posedge clk); while (char_stall);
		eval_char(it);
		items_sent++;
	endtask

	task automatic send_expr(input char_q_t s);
		for (int i = 0; i < s.size(); i++) begin
			send_char(s[i], i == s.size() - 1);
		end
	endtask

	// Hold off the sender until every queued result has been taken
	task automatic wait_results_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (predicted_results.size() != 0);
	endtask

	function automatic char_q_t str_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q = {q, s[i]};
		return q;
	endfunction

	function automatic char_q_t number_chars(input longint unsigned n);
		char_q_t digits;
		do begin
			digits.push_front(CH_ZERO + 8'(n % 10));
			n = n / 10;
		end while (n != 0);
		return digits;
	endfunction

	// Random expression: mostly well formed, some noise and broken shapes
	function automatic char_q_t build_expr();
		char_q_t         q;
		int              terms;
		int              sel;
		longint unsigned n;
		logic [7:0]      ops[4];
		longint unsigned extremes[7];
		ops      = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};
		extremes = '{64'd0, 64'd1, 64'd2147483647, 64'd2147483648, 64'd4294967295,
			64'd4294967296, 64'd9999999999};
		sel = $urandom_range(0, 15);
		if (sel == 0) begin
			// most negative divided by minus one
			q = {number_chars(64'd2147483648), CH_DIVIDE, number_chars(64'd4294967295)};
			return q;
		end
		if (sel == 1) begin
			// pure noise bytes
			repeat ($urandom_range(1, 8)) q = {q, 8'($urandom_range(0, 255))};
			return q;
		end
		if ($urandom_range(0, 7) == 0) q = {q, ops[$urandom_range(0, 1)]};
		terms = $urandom_range(1, 6);
		for (int k = 0; k < terms; k++) begin
			if (k > 0) begin
				if ($urandom_range(0, 4) == 0) q = {q, CH_SPACE};
				q = {q, ops[$urandom_range(0, 3)]};
				if ($urandom_range(0, 15) == 0) q = {q, 8'($urandom_range(0, 255))};
				if ($urandom_range(0, 4) == 0) q = {q, CH_SPACE};
			end
			sel = $urandom_range(0, 19);
			if (sel < 11)
				n = $urandom_range(0, 9);
			else if (sel < 16)
				n = $urandom_range(0, 999);
			else if (sel < 18)
				n = extremes[$urandom_range(0, 6)];
			else if (sel == 18)
				n = {$urandom, $urandom} % 64'd100000000000;
			else
				n = $urandom;
			if ($urandom_range(0, 15) == 0) q = {q, CH_ZERO};
			q = {q, number_chars(n)};
		end
		// trailing space, operator or stray byte on the last transaction
		sel = $urandom_range(0, 11);
		if (sel == 0) q = {q, CH_SPACE};
		else if (sel == 1) q = {q, ops[$urandom_range(0, 3)]};
		else if (sel == 2) q = {q, 8'($urandom_range(0, 255))};
		return q;
	endfunction

	// Precedence of * and / over + and -, single digit
	task automatic test_precedence();
		send_expr(str_chars("1-8*3/2 "));
		send_expr(str_chars("9"));
	endtask

	// Division by zero, unknown operator, first error kept
	task automatic test_error_status();
		send_expr(str_chars("7/0"));
		send_expr('{8'h39, 8'hFF, 8'h33});
		send_expr(str_chars("4/0$1"));
	endtask

	// Byte zero as a lone last char, leading sign, operator as last char
	task automatic test_boundary_chars();
		send_expr('{8'h00});
		send_expr(str_chars("-5 +"));
	endtask

	task automatic test_random_expressions(input int item_goal);
		char_q_t expr;
		while (items_sent < item_goal) begin
			// stretches at full rate on both sides
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) wait_results_drained();
			expr = build_expr();
			send_expr(expr);
		end
		idle_on = 1'b1;
	endtask

	// Result side: random stall before each transaction
	initial begin : result_sink
		int hold;
		result_stall = 1'b0;
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
		end
	end

	// Compare each accepted result against the oldest prediction
	always @(posedge clk) begin : result_check
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d status=%0d",
					result_data.value, result_data.status));
			end else begin
				want = predicted_results.pop_front();
				if (result_data.value !== want.value)
					report_mismatch($sformatf("value got %0d want %0d",
						result_data.value, want.value));
				if (result_data.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						result_data.status, want.status));
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_precedence();
		test_error_status();
		test_boundary_chars();
		wait_results_drained();
		test_random_expressions(ITEM_GOAL);

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (predicted_results.size() != 0)
			report_mismatch("predicted results left over");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
